>>> rtl/core/pvki_pkg.sv
// pvki_pkg: shared types, codes and defaults for the path/value key interleaver.
// No dependencies; pvki_seq and the top level import this package.
`timescale 1ns / 1ps
`default_nettype none

package pvki_pkg;

  // Default buffer depths
  localparam int PVKI_PATH_DEPTH  = 32;
  localparam int PVKI_VALUE_DEPTH = 32;

  // Configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 8;
  localparam int MODE_W      = 3;

  localparam logic [CFG_INDEX_W-1:0] CFG_MODE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SEP  = 1'd1;

  // Interleave modes; codes 5..7 behave as path-then-value
  localparam logic [MODE_W-1:0] MODE_ZORDER      = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ALTERNATE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LABEL       = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PATH_FIRST  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VALUE_FIRST = 3'd4;

  localparam logic [7:0] SEP_RESET = 8'd47;

  // Byte source tags
  localparam logic SRC_PATH  = 1'b0;
  localparam logic SRC_VALUE = 1'b1;

  typedef struct packed {
    logic [7:0]  key_byte;
    logic        byte_source;
    logic        byte_present;
    logic        key_done;
    logic [63:0] document_id;
  } key_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        out_source;
    logic        out_last;
    logic [63:0] out_document;
    logic        overflow_flag;
  } key_result_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [7:0]        separator;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PREP,
    ST_EMIT
  } seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/pvki_store.sv
// pvki_store: byte buffer, one write port and one read port with registered data.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module pvki_store #(
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/pvki_div.sv
// pvki_div: restoring divider, one quotient bit per cycle on a shared subtractor.
// Uses no package items; done pulses once the last quotient bit has been shifted in.
`timescale 1ns / 1ps
`default_nettype none

module pvki_div #(
  parameter int W = 6,
  localparam int CNW = $clog2(W + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  logic [CNW-1:0] cnt;
  logic [W-1:0]   rem;
  logic [W-1:0]   quo;
  logic [W-1:0]   dsr;
  logic [W:0]     trial;
  logic [W:0]     diff;
  logic           ge;
  logic [W-1:0]   rem_next;
  logic [W-1:0]   quo_next;

  // One trial subtraction per step
  always_comb begin
    trial    = {rem, quo[W-1]};
    diff     = trial - {1'b0, dsr};
    ge       = (trial >= {1'b0, dsr});
    rem_next = ge ? diff[W-1:0] : trial[W-1:0];
    quo_next = (quo << 1) | W'(ge);
  end

  // Control: step counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNW'(W);
      done <= 1'b0;
    end else begin
      done <= (cnt == CNW'(1));
      if (cnt != '0) begin
        cnt <= cnt - CNW'(1);
      end
    end
  end

  // Datapath: remainder and dividend/quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dsr <= divisor;
    end else if (cnt != '0) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

>>> rtl/core/pvki_seq.sv
// pvki_seq: request loading, fill counts and the emission sequencer for all modes.
// Depends on pvki_pkg; drives the two byte stores and the shared divider.
`timescale 1ns / 1ps
`default_nettype none

module pvki_seq
  import pvki_pkg::*;
#(
  parameter int PATH_DEPTH  = PVKI_PATH_DEPTH,
  parameter int VALUE_DEPTH = PVKI_VALUE_DEPTH,
  localparam int PAW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1,
  localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1,
  localparam int PCW = $clog2(PATH_DEPTH + 1),
  localparam int VCW = $clog2(VALUE_DEPTH + 1),
  localparam int DW  = (PCW > VCW) ? PCW : VCW
) (
  input  logic            clk,
  input  logic            rst,
  input  cfg_t            cfg,
  input  logic            start,
  input  key_item_t       item,
  output logic            busy,
  output logic [7:0]      wdata,
  output logic            p_we,
  output logic [PAW-1:0]  p_waddr,
  output logic [PAW-1:0]  p_raddr,
  input  logic [7:0]      p_rdata,
  output logic            v_we,
  output logic [VAW-1:0]  v_waddr,
  output logic [VAW-1:0]  v_raddr,
  input  logic [7:0]      v_rdata,
  output logic            div_start,
  output logic [DW-1:0]   div_dividend,
  output logic [DW-1:0]   div_divisor,
  input  logic            div_done,
  input  logic [DW-1:0]   div_quotient,
  output logic            result_valid,
  output key_result_t     result
);

  seq_state_t state, state_next;

  logic [PCW-1:0] p_count, p_count_next;
  logic [VCW-1:0] v_count, v_count_next;
  logic [PCW-1:0] p_idx, p_idx_next;
  logic [VCW-1:0] v_idx, v_idx_next;
  logic [PCW-1:0] run_left, run_left_next;
  logic           overflow, overflow_next;
  logic           lbl_in, lbl_in_next;
  logic           lbl_vturn, lbl_vturn_next;
  logic [63:0]    doc, doc_next;
  logic           result_valid_next;
  key_result_t    result_next;

  logic           accept;
  logic           p_full, v_full;
  logic [PCW-1:0] p_count_load;
  logic [VCW-1:0] v_count_load;
  logic           ovf_load;
  logic           p_left, v_left;
  logic           take_value;
  logic           is_last;
  logic           end_label;
  logic [PCW-1:0] run_len;

  assign busy    = (state != ST_IDLE);
  assign wdata   = item.key_byte;
  assign p_waddr = p_count[PAW-1:0];
  assign v_waddr = v_count[VAW-1:0];
  assign run_len = div_quotient[PCW-1:0];

  // Store reads follow the next index so data lines up with each emit cycle
  assign p_raddr = p_idx_next[PAW-1:0];
  assign v_raddr = v_idx_next[VAW-1:0];

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, loading and emission
  always_comb begin
    state_next        = state;
    p_count_next      = p_count;
    v_count_next      = v_count;
    p_idx_next        = p_idx;
    v_idx_next        = v_idx;
    run_left_next     = run_left;
    overflow_next     = overflow;
    lbl_in_next       = lbl_in;
    lbl_vturn_next    = lbl_vturn;
    doc_next          = doc;
    result_valid_next = 1'b0;
    result_next       = result;
    div_start         = 1'b0;
    take_value        = 1'b0;
    is_last           = 1'b0;
    end_label         = 1'b0;

    // Loading side
    accept       = start && (state == ST_IDLE);
    p_full       = (p_count == PCW'(PATH_DEPTH));
    v_full       = (v_count == VCW'(VALUE_DEPTH));
    p_we         = accept && item.byte_present && (item.byte_source == SRC_PATH) && !p_full;
    v_we         = accept && item.byte_present && (item.byte_source == SRC_VALUE) && !v_full;
    p_count_load = p_count + PCW'(p_we);
    v_count_load = v_count + VCW'(v_we);
    ovf_load     = overflow || (accept && item.byte_present &&
                   ((item.byte_source == SRC_PATH) ? p_full : v_full));
    div_dividend = DW'(p_count_load);
    div_divisor  = DW'(v_count_load);

    p_left = (p_idx < p_count);
    v_left = (v_idx < v_count);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          p_count_next  = p_count_load;
          v_count_next  = v_count_load;
          overflow_next = ovf_load;
          if (item.key_done) begin
            doc_next = item.document_id;
            if ((p_count_load == '0) && (v_count_load == '0)) begin
              // empty key: nothing to send, start over
              overflow_next = 1'b0;
            end else if ((cfg.mode == MODE_ZORDER) && (v_count_load != '0)) begin
              div_start  = 1'b1;
              state_next = ST_DIV;
            end else begin
              state_next = ST_PREP;
            end
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          state_next = ST_EMIT;
        end
      end

      ST_PREP: begin
        state_next = ST_EMIT;
      end

      ST_EMIT: begin
        // pick the source of this byte
        case (cfg.mode)
          MODE_ZORDER: begin
            take_value = (run_left == '0) && v_left;
          end
          MODE_ALTERNATE: begin
            take_value = v_left && ((PCW'(v_idx) < p_idx) || !p_left);
          end
          MODE_LABEL: begin
            if (lbl_in) begin
              take_value = 1'b0;
            end else if (lbl_vturn && v_left) begin
              take_value = 1'b1;
            end else begin
              take_value = !p_left;
            end
          end
          MODE_VALUE_FIRST: begin
            take_value = v_left;
          end
          default: begin
            take_value = !p_left;
          end
        endcase

        if (take_value) begin
          v_idx_next = v_idx + VCW'(1);
          is_last    = (v_idx + VCW'(1) == v_count) && !p_left;
          if (cfg.mode == MODE_ZORDER) begin
            run_left_next = p_left ? run_len : '0;
          end
          if (cfg.mode == MODE_LABEL) begin
            lbl_vturn_next = 1'b0;
          end
        end else begin
          p_idx_next = p_idx + PCW'(1);
          is_last    = (p_idx + PCW'(1) == p_count) && !v_left;
          if ((cfg.mode == MODE_ZORDER) && (run_left != '0)) begin
            run_left_next = run_left - PCW'(1);
          end
          if (cfg.mode == MODE_LABEL) begin
            // first byte of a label never ends it unless the path runs out
            end_label      = (p_idx + PCW'(1) == p_count) ||
                             (lbl_in && (p_rdata == cfg.separator));
            lbl_in_next    = !end_label;
            lbl_vturn_next = end_label;
          end
        end

        result_valid_next         = 1'b1;
        result_next.out_byte      = take_value ? v_rdata : p_rdata;
        result_next.out_source    = take_value ? SRC_VALUE : SRC_PATH;
        result_next.out_last      = is_last;
        result_next.out_document  = doc;
        result_next.overflow_flag = overflow;

        if (is_last) begin
          state_next     = ST_IDLE;
          p_count_next   = '0;
          v_count_next   = '0;
          p_idx_next     = '0;
          v_idx_next     = '0;
          run_left_next  = '0;
          overflow_next  = 1'b0;
          lbl_in_next    = 1'b0;
          lbl_vturn_next = 1'b0;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      p_count      <= '0;
      v_count      <= '0;
      p_idx        <= '0;
      v_idx        <= '0;
      run_left     <= '0;
      overflow     <= 1'b0;
      lbl_in       <= 1'b0;
      lbl_vturn    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      p_count      <= p_count_next;
      v_count      <= v_count_next;
      p_idx        <= p_idx_next;
      v_idx        <= v_idx_next;
      run_left     <= run_left_next;
      overflow     <= overflow_next;
      lbl_in       <= lbl_in_next;
      lbl_vturn    <= lbl_vturn_next;
      result_valid <= result_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    doc    <= doc_next;
    result <= result_next;
  end

  // Checks
  a_last_ends_key: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result.out_last) |=> !result_valid)
    else $error("result strobe after the last byte of a key");

  a_key_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.out_last) |=> result_valid)
    else $error("gap inside an emitted key");

  a_emit_has_byte: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> ((p_idx < p_count) || (v_idx < v_count)))
    else $error("emit cycle with both buffers used up");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside its wait state");

  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> ((p_idx == '0) && (v_idx == '0) && (run_left == '0)))
    else $error("read indices not cleared between keys");

endmodule

`default_nettype wire

>>> rtl/core/path_value_key_interleaver.sv
// path_value_key_interleaver: top level with configuration registers.
// Depends on pvki_pkg, pvki_store, pvki_div and pvki_seq.
`timescale 1ns / 1ps
`default_nettype none

// Each request (start high while busy is low) stores its byte, if any, in the
// path or value buffer; a full buffer drops the byte and sets the overflow flag
// for the key. The request marked key_done raises busy and starts emission: a
// preparation state (z-order with a non-empty value string instead waits for the
// bit-serial divider that computes the run length), then one result per cycle
// for all P+V stored bytes, each shown for exactly one cycle with result_valid.
// The receiver cannot stall: it must take every result in the cycle it is shown.
// busy drops in the cycle that carries the last byte. An empty key emits nothing.
module path_value_key_interleaver
  import pvki_pkg::*;
#(
  parameter int PATH_DEPTH  = PVKI_PATH_DEPTH,
  parameter int VALUE_DEPTH = PVKI_VALUE_DEPTH,
  localparam int PAW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1,
  localparam int VAW = (VALUE_DEPTH > 1) ? $clog2(VALUE_DEPTH) : 1,
  localparam int PCW = $clog2(PATH_DEPTH + 1),
  localparam int VCW = $clog2(VALUE_DEPTH + 1),
  localparam int DW  = (PCW > VCW) ? PCW : VCW
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   start,
  input  key_item_t              item,
  output logic                   busy,
  output logic                   result_valid,
  output key_result_t            result
);

  cfg_t           cfg;
  logic [7:0]     wdata;
  logic           p_we, v_we;
  logic [PAW-1:0] p_waddr, p_raddr;
  logic [VAW-1:0] v_waddr, v_raddr;
  logic [7:0]     p_rdata, v_rdata;
  logic           div_start, div_done;
  logic [DW-1:0]  div_dividend, div_divisor, div_quotient;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= MODE_ZORDER;
      cfg.separator <= SEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_MODE: cfg.mode      <= cfg_data[MODE_W-1:0];
        CFG_SEP:  cfg.separator <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Byte buffers
  pvki_store #(.DEPTH(PATH_DEPTH)) u_path_store (
    .clk   (clk),
    .we    (p_we),
    .waddr (p_waddr),
    .wdata (wdata),
    .raddr (p_raddr),
    .rdata (p_rdata)
  );

  pvki_store #(.DEPTH(VALUE_DEPTH)) u_value_store (
    .clk   (clk),
    .we    (v_we),
    .waddr (v_waddr),
    .wdata (wdata),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  // Run length divider for z-order
  pvki_div #(.W(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Loading and emission sequencer
  pvki_seq #(
    .PATH_DEPTH  (PATH_DEPTH),
    .VALUE_DEPTH (VALUE_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .start        (start),
    .item         (item),
    .busy         (busy),
    .wdata        (wdata),
    .p_we         (p_we),
    .p_waddr      (p_waddr),
    .p_raddr      (p_raddr),
    .p_rdata      (p_rdata),
    .v_we         (v_we),
    .v_waddr      (v_waddr),
    .v_raddr      (v_raddr),
    .v_rdata      (v_rdata),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule

`default_nettype wire
